/* design/npc_pkg.sv */
// Shared types, constants and helper functions of the nearest palette color block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package npc_pkg;

  localparam int unsigned LANES  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned DIST_W = 18;
  localparam int unsigned CFG_W  = 5;

  typedef enum logic [0:0] {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] dist_sq;
    logic [IDX_W-1:0]  idx;
    rgb_t              color;
  } cand_t;

  function automatic logic [CH_W-1:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // The lower-index candidate is passed as lo, so it keeps ties.
  function automatic cand_t pick(cand_t lo, cand_t hi);
    if (hi.vld && (!lo.vld || (hi.dist_sq < lo.dist_sq))) begin
      pick = hi;
    end else begin
      pick = lo;
    end
  endfunction

endpackage

`default_nettype wire

/* design/npc_palette.sv */
// Palette store: one 24-bit color register per entry, all read in parallel.
// Depends on npc_pkg.
`default_nettype none

module npc_palette import npc_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] widx_i,
  input  wire rgb_t             wcolor_i,
  output rgb_t                  colors_o [LANES]
);

  for (genvar i = 0; i < LANES; i++) begin : g_entry
    if (i < DEPTH) begin : g_used
      rgb_t entry_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          entry_q <= '0;
        end else if (we_i && (widx_i == IDX_W'(i))) begin
          entry_q <= wcolor_i;
        end
      end
      assign colors_o[i] = entry_q;
    end else begin : g_unused
      assign colors_o[i] = '0;
    end
  end

endmodule

`default_nettype wire

/* design/npc_dist.sv */
// Distance stages: per-entry channel differences, then squared distances.
// Depends on npc_pkg.
`default_nettype none

module npc_dist import npc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire rgb_t             pixel_i,
  input  wire rgb_t             colors_i [LANES],
  input  wire logic [LANES-1:0] use_i,
  output cand_t                 cand_o [LANES]
);

  rgb_t             diff_d  [LANES];
  rgb_t             diff_q  [LANES];
  rgb_t             color_q [LANES];
  logic [LANES-1:0] use_q;
  cand_t            cand_d  [LANES];
  cand_t            cand_q  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff_d[i].r = abs_diff(pixel_i.r, colors_i[i].r);
      diff_d[i].g = abs_diff(pixel_i.g, colors_i[i].g);
      diff_d[i].b = abs_diff(pixel_i.b, colors_i[i].b);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cand_d[i].vld     = use_q[i];
      cand_d[i].dist_sq = DIST_W'({8'd0, diff_q[i].r} * {8'd0, diff_q[i].r})
                        + DIST_W'({8'd0, diff_q[i].g} * {8'd0, diff_q[i].g})
                        + DIST_W'({8'd0, diff_q[i].b} * {8'd0, diff_q[i].b});
      cand_d[i].idx     = IDX_W'(i);
      cand_d[i].color   = color_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      use_q <= use_i;
      for (int i = 0; i < LANES; i++) begin
        diff_q[i]  <= diff_d[i];
        color_q[i] <= colors_i[i];
        cand_q[i]  <= cand_d[i];
      end
    end
  end

  assign cand_o = cand_q;

endmodule

`default_nettype wire

/* design/npc_select.sv */
// Minimum search: a two-stage registered comparison tree over all candidates.
// Depends on npc_pkg.
`default_nettype none

module npc_select import npc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire cand_t cand_i [LANES],
  output cand_t      win_o
);

  localparam int unsigned L1 = LANES / 2;
  localparam int unsigned L2 = LANES / 4;

  cand_t lvl1   [L1];
  cand_t lvl2_d [L2];
  cand_t lvl2_q [L2];
  cand_t lvl3   [2];
  cand_t win_d;
  cand_t win_q;

  always_comb begin
    for (int i = 0; i < L1; i++) begin
      lvl1[i] = pick(cand_i[2*i], cand_i[2*i+1]);
    end
    for (int i = 0; i < L2; i++) begin
      lvl2_d[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lvl3[i] = pick(lvl2_q[2*i], lvl2_q[2*i+1]);
    end
    win_d = pick(lvl3[0], lvl3[1]);
    // With no entry in use the result carries zeros.
    if (!win_d.vld) begin
      win_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < L2; i++) begin
        lvl2_q[i] <= lvl2_d[i];
      end
      win_q <= win_d;
    end
  end

  assign win_o = win_q;

endmodule

`default_nettype wire

/* design/nearest_palette_color_top.sv */
// Nearest palette color: top level with handshake control and pipeline valid bits.
// Depends on npc_pkg, npc_palette, npc_dist and npc_select.
//
// The input channel carries one word per command. A write word stores red, green
// and blue at entry_index and gives no result; an index at or beyond the store
// depth is dropped. A lookup word gives one result word: the lowest-index entry
// of smallest squared RGB distance among the first palette_size entries, or
// found low with zero fields when no entry is in use.
// palette_size is loaded through cfg_we_i and cfg_wdata_i; the user must load it only
// while the block is idle, which the block itself does not enforce. The pipeline takes
// one word per cycle while the receiver does not stall. A lookup passes one register
// stage each for channel differences, squared distances, the first half of the compare
// tree and the second half.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops until
// the output word is taken, so nothing is lost or repeated.
// Reset clears the palette to black, palette_size to zero and all valid bits.
`default_nettype none

module nearest_palette_color_top import npc_pkg::*; #(
  parameter int unsigned MAX_COLORS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             command_i,
  input  wire logic [IDX_W-1:0] entry_index_i,
  input  wire logic [CH_W-1:0]  red_i,
  input  wire logic [CH_W-1:0]  green_i,
  input  wire logic [CH_W-1:0]  blue_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      best_index_o,
  output logic [CH_W-1:0]       best_red_o,
  output logic [CH_W-1:0]       best_green_o,
  output logic [CH_W-1:0]       best_blue_o
);

  localparam int unsigned DEPTH = (MAX_COLORS < LANES) ? MAX_COLORS : LANES;

  logic             en;
  logic             accept;
  logic             write_acc;
  logic             lookup_acc;
  logic [CFG_W-1:0] palette_size_q;
  logic             s1_vld_q;
  logic             s1_vld_d;
  logic             s2_vld_q;
  logic             s3_vld_q;
  logic             out_vld_q;
  rgb_t             pixel;
  rgb_t             colors [LANES];
  logic [LANES-1:0] lane_use;
  cand_t            cand   [LANES];
  cand_t            win;

  assign en         = !out_vld_q || out_ready_i;
  assign accept     = in_valid_i && en;
  assign write_acc  = accept && (command_i == CMD_WRITE);
  assign lookup_acc = accept && (command_i == CMD_LOOKUP);
  assign s1_vld_d   = lookup_acc;
  assign pixel      = '{r: red_i, g: green_i, b: blue_i};

  for (genvar i = 0; i < LANES; i++) begin : g_use
    assign lane_use[i] = (i < DEPTH) && (CFG_W'(i) < palette_size_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= '0;
    end else if (cfg_we_i) begin
      palette_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  npc_palette #(
    .DEPTH (DEPTH)
  ) u_palette (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (write_acc),
    .widx_i   (entry_index_i),
    .wcolor_i (pixel),
    .colors_o (colors)
  );

  npc_dist u_dist (
    .clk_i    (clk_i),
    .en_i     (en),
    .pixel_i  (pixel),
    .colors_i (colors),
    .use_i    (lane_use),
    .cand_o   (cand)
  );

  npc_select u_select (
    .clk_i  (clk_i),
    .en_i   (en),
    .cand_i (cand),
    .win_o  (win)
  );

  assign in_ready_o   = en;
  assign out_valid_o  = out_vld_q;
  assign found_o      = win.vld;
  assign best_index_o = win.idx;
  assign best_red_o   = win.color.r;
  assign best_green_o = win.color.g;
  assign best_blue_o  = win.color.b;

  a_lookup_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc ##1 en ##1 en ##1 en |=> out_valid_o)
    else $error("Lookup word did not reach the output after three enabled cycles.");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (best_index_o == '0) && (best_red_o == '0)
                                && (best_green_o == '0) && (best_blue_o == '0))
    else $error("Result without a hit carries nonzero fields.");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> ({1'b0, best_index_o} < palette_size_q))
    else $error("Winning index lies outside the entries in use.");

endmodule

`default_nettype wire

/* bench/tb_nearest_palette_color_top.sv */
// Self-checking bench for nearest_palette_color_top: palette writes, nearest-color lookups
// and palette_size settings under random sender gaps and receiver stalls.
// Depends on npc_pkg and the nearest_palette_color_top RTL only.
module tb_nearest_palette_color_top;
  import npc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLORS = 16;
  localparam int unsigned LATENCY = 3;
  localparam int unsigned DIST_LIMIT = 250000;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 240;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    rgb_t             color;
  } lookup_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             command_i = 1'b0;
  logic [IDX_W-1:0] entry_index_i = '0;
  logic [CH_W-1:0]  red_i = '0;
  logic [CH_W-1:0]  green_i = '0;
  logic [CH_W-1:0]  blue_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b1;
  logic             found_o;
  logic [IDX_W-1:0] best_index_o;
  logic [CH_W-1:0]  best_red_o;
  logic [CH_W-1:0]  best_green_o;
  logic [CH_W-1:0]  best_blue_o;

  rgb_t             palette_model [COLORS];
  int unsigned      size_model = 0;
  lookup_result_t   pending_results [$];
  int unsigned      fail_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      gap_max = 0;
  int unsigned      stall_max = 0;
  int unsigned      stall_left = 0;

  nearest_palette_color_top #(.MAX_COLORS(COLORS)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .entry_index_i(entry_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .best_index_o (best_index_o),
    .best_red_o   (best_red_o),
    .best_green_o (best_green_o),
    .best_blue_o  (best_blue_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(int unsigned max_wait);
    return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CH_W-1:0] near_chan(logic [CH_W-1:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CH_W'(v);
  endfunction

  function automatic int unsigned sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // Lowest index wins ties because only a strictly smaller distance replaces the best.
  function automatic lookup_result_t nearest_entry(rgb_t px);
    lookup_result_t res;
    int unsigned    n;
    int unsigned    best_d;
    int unsigned    d;
    res = '0;
    n = (size_model > COLORS) ? COLORS : size_model;
    best_d = DIST_LIMIT;
    for (int unsigned i = 0; i < n; i++) begin
      d = sq(px.r, palette_model[i].r) + sq(px.g, palette_model[i].g)
          + sq(px.b, palette_model[i].b);
      if (d < best_d) begin
        best_d = d;
        res.found = 1'b1;
        res.idx = IDX_W'(i);
        res.color = palette_model[i];
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    lookup_result_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: expected no result word, got index %0d", $time, best_index_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("found", exp_r.found, found_o);
        check_field("best_index", exp_r.idx, best_index_o);
        check_field("best_red", exp_r.color.r, best_red_o);
        check_field("best_green", exp_r.color.g, best_green_o);
        check_field("best_blue", exp_r.color.b, best_blue_o);
      end
      stall_left = draw_wait(stall_max);
      if (stall_left > 0) out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready_i <= 1'b1;
    end
  end

  task automatic send_word(cmd_e cmd, logic [IDX_W-1:0] idx, rgb_t color);
    int unsigned gap;
    gap = draw_wait(gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    entry_index_i <= idx;
    red_i <= color.r;
    green_i <= color.g;
    blue_i <= color.b;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_WRITE) begin
      palette_model[idx] = color;
    end else begin
      pending_results = {pending_results, nearest_entry(color)};
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic set_palette_size(logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_model = value;
  endtask

  task automatic test_unwritten_entries();
    set_palette_size(5'd3);
    send_word(CMD_LOOKUP, 4'd0, '{8'd200, 8'd10, 8'd10});
    send_word(CMD_LOOKUP, 4'd15, '{8'd0, 8'd0, 8'd0});
  endtask

  task automatic test_empty_palette();
    set_palette_size(5'd0);
    send_word(CMD_LOOKUP, 4'd0, '{8'd0, 8'd0, 8'd0});
    send_word(CMD_LOOKUP, 4'd15, '{8'd255, 8'd255, 8'd255});
    send_word(CMD_WRITE, 4'd0, '{8'd255, 8'd255, 8'd255});
    send_word(CMD_LOOKUP, 4'd0, '{8'd255, 8'd255, 8'd255});
  endtask

  task automatic test_extremes_and_ties();
    set_palette_size(5'd1);
    send_word(CMD_LOOKUP, 4'd0, '{8'd0, 8'd0, 8'd0});
    send_word(CMD_WRITE, 4'd1, '{8'd100, 8'd100, 8'd100});
    send_word(CMD_WRITE, 4'd2, '{8'd102, 8'd100, 8'd100});
    send_word(CMD_WRITE, 4'd15, '{8'd255, 8'd255, 8'd255});
    set_palette_size(5'd16);
    send_word(CMD_LOOKUP, 4'd0, '{8'd101, 8'd100, 8'd100});
    send_word(CMD_LOOKUP, 4'd0, '{8'd255, 8'd255, 8'd255});
    send_word(CMD_LOOKUP, 4'd0, '{8'd103, 8'd100, 8'd100});
    send_word(CMD_LOOKUP, 4'd0, '{8'd0, 8'd0, 8'd1});
  endtask

  task automatic test_oversized_size();
    send_word(CMD_WRITE, 4'd15, '{8'd1, 8'd254, 8'd128});
    set_palette_size(5'd31);
    send_word(CMD_LOOKUP, 4'd0, '{8'd1, 8'd254, 8'd128});
    send_word(CMD_LOOKUP, 4'd0, '{8'd0, 8'd255, 8'd127});
    set_palette_size(5'd17);
    send_word(CMD_LOOKUP, 4'd0, '{8'd2, 8'd250, 8'd130});
  endtask

  task automatic test_random_traffic();
    int unsigned   sizes [8] = '{16, 1, 31, 8, 0, 17, 0, 16};
    int unsigned   gaps [8] = '{0, 14, 5, 0, 14, 3, 14, 0};
    int unsigned   stalls [8] = '{0, 0, 14, 14, 5, 14, 3, 0};
    int unsigned   in_use;
    int unsigned   pick_i;
    rgb_t          color;
    logic [IDX_W-1:0] idx;
    for (int p = 0; p < 8; p++) begin
      set_palette_size((p == 6) ? CFG_W'($urandom_range(2, 15)) : CFG_W'(sizes[p]));
      gap_max = gaps[p];
      stall_max = stalls[p];
      in_use = (size_model > COLORS) ? COLORS : size_model;
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (p == 2 && w == PHASE_WORDS / 2) wait_idle();
        idx = IDX_W'($urandom_range(0, COLORS - 1));
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 5) == 0) begin
            color = palette_model[$urandom_range(0, COLORS - 1)];
          end else begin
            color = '{rand_chan(), rand_chan(), rand_chan()};
          end
          send_word(CMD_WRITE, idx, color);
        end else begin
          pick_i = (in_use == 0) ? 0 : $urandom_range(0, in_use - 1);
          case ($urandom_range(0, 3))
            0: color = palette_model[pick_i];
            1: color = '{near_chan(palette_model[pick_i].r), near_chan(palette_model[pick_i].g),
                         near_chan(palette_model[pick_i].b)};
            default: color = '{rand_chan(), rand_chan(), rand_chan()};
          endcase
          send_word(CMD_LOOKUP, idx, color);
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < COLORS; i++) palette_model[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_unwritten_entries();
    test_empty_palette();
    test_extremes_and_ties();
    test_oversized_size();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
